// ----- rtl/fpwu_pkg.sv -----
// Shared types and constants for the framebuffer pixel write unit.
`timescale 1ns / 1ps
`default_nettype none

package fpwu_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_PIXEL_FORMAT = 3'd0;
  localparam logic [2:0] CFG_BANKED_MODE  = 3'd1;
  localparam logic [2:0] CFG_SCREEN_W     = 3'd2;
  localparam logic [2:0] CFG_SCREEN_H     = 3'd3;
  localparam logic [2:0] CFG_ROW_BYTES    = 3'd4;
  localparam logic [2:0] CFG_GRANULES     = 3'd5;
  localparam logic [2:0] CFG_SECOND_WIN   = 3'd6;

  // Pixel formats
  localparam logic [2:0] FMT_PLANAR = 3'd0;
  localparam logic [2:0] FMT_8BPP   = 3'd1;
  localparam logic [2:0] FMT_16BPP  = 3'd2;
  localparam logic [2:0] FMT_24BPP  = 3'd3;
  localparam logic [2:0] FMT_32BPP  = 3'd4;

  localparam logic [7:0] MASK_TOP_BIT = 8'h80;
  localparam logic [1:0] LAST_PLANE   = 2'd3;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_PLANE = 2'd2
  } kind_e;

  // Controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       load_line;
    logic       load_addr;
    logic       load_out;
    logic [1:0] plane;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic drop;
    logic last;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/fpwu_ctrl.sv -----
// Sequencing state machine for the framebuffer pixel write unit.
`timescale 1ns / 1ps
`default_nettype none

module fpwu_ctrl import fpwu_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_ADDR = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] plane_q, plane_d;
  logic       out_valid_q, out_valid_d;
  logic       load;

  assign load = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    plane_d     = plane_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        plane_d = 2'd0;
        if (in_valid_i) begin
          state_d = S_MUL;
        end
      end
      S_MUL:  state_d = S_ADDR;
      S_ADDR: state_d = sts_i.drop ? S_IDLE : S_EMIT;
      S_EMIT: begin
        if (load) begin
          out_valid_d = 1'b1;
          plane_d     = plane_q + 2'd1;
          if (sts_i.last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      plane_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      plane_q     <= plane_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign cmd_o.load_in   = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.load_line = (state_q == S_MUL);
  assign cmd_o.load_addr = (state_q == S_ADDR);
  assign cmd_o.load_out  = load;
  assign cmd_o.plane     = plane_q;

endmodule

`default_nettype wire

// ----- rtl/fpwu_dp.sv -----
// Datapath: configuration, address arithmetic, bank tracking and result register.
`timescale 1ns / 1ps
`default_nettype none

module fpwu_dp import fpwu_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic [15:0] pos_x_i,
  input  wire logic [15:0] pos_y_i,
  input  wire logic [31:0] pixel_color_i,
  input  wire cmd_t        cmd_i,
  output sts_t             sts_o,
  output logic [1:0]       kind_o,
  output logic [31:0]      address_o,
  output logic [31:0]      write_data_o,
  output logic [2:0]       byte_count_o,
  output logic [1:0]       plane_o,
  output logic [7:0]       bit_mask_o,
  output logic             set_bit_o,
  output logic             window_select_o,
  output logic [15:0]      window_position_o,
  output logic             last_o
);

  // Configuration
  logic [2:0]  fmt_q;
  logic        banked_q;
  logic [15:0] width_q, height_q, row_bytes_q;
  logic [6:0]  gran_q;
  logic        win_sel_q;

  // Bank tracking
  logic        bank_known_q, bank_known_d;
  logic [15:0] cur_bank_q, cur_bank_d;

  // Item payload and intermediates
  logic [15:0] x_q, y_q;
  logic [31:0] c_q;
  logic [31:0] line_q, addr_q, offset;
  logic        drop_q;

  // Result register
  kind_e       kind_q, kind_d;
  logic [31:0] address_q, address_d, data_q, data_d;
  logic [2:0]  count_q, count_d;
  logic [1:0]  plane_q, plane_d;
  logic [7:0]  mask_q, mask_d;
  logic        set_q, set_d, wsel_q, wsel_d, last_q;
  logic [15:0] wpos_q, wpos_d;

  logic        planar, need_move, res_last;
  logic [15:0] bank;
  logic [22:0] wpos_full;
  logic [31:0] color_masked;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= FMT_8BPP;
      banked_q    <= 1'b0;
      width_q     <= 16'd0;
      height_q    <= 16'd0;
      row_bytes_q <= 16'd0;
      gran_q      <= 7'd1;
      win_sel_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PIXEL_FORMAT: fmt_q       <= cfg_data_i[2:0];
        CFG_BANKED_MODE:  banked_q    <= cfg_data_i[0];
        CFG_SCREEN_W:     width_q     <= cfg_data_i;
        CFG_SCREEN_H:     height_q    <= cfg_data_i;
        CFG_ROW_BYTES:    row_bytes_q <= cfg_data_i;
        CFG_GRANULES:     gran_q      <= cfg_data_i[6:0];
        CFG_SECOND_WIN:   win_sel_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign planar = (fmt_q == FMT_PLANAR);

  always_comb begin
    unique case (fmt_q)
      FMT_8BPP:  offset = {16'd0, x_q};
      FMT_16BPP: offset = {15'd0, x_q, 1'b0};
      FMT_24BPP: offset = {16'd0, x_q} + {15'd0, x_q, 1'b0};
      FMT_32BPP: offset = {14'd0, x_q, 2'b0};
      default:   offset = {19'd0, x_q[15:3]};
    endcase
  end

  always_comb begin
    unique case (fmt_q)
      FMT_8BPP:  color_masked = {24'd0, c_q[7:0]};
      FMT_16BPP: color_masked = {16'd0, c_q[15:0]};
      FMT_24BPP: color_masked = {8'd0, c_q[23:0]};
      default:   color_masked = c_q;
    endcase
  end

  assign bank      = addr_q[31:16];
  assign wpos_full = bank * gran_q;
  assign need_move = banked_q && !planar && (!bank_known_q || (bank != cur_bank_q));
  // A bank move is followed by the write itself, so it is never the last result.
  assign res_last  = planar ? (cmd_i.plane == LAST_PLANE) : !need_move;

  always_comb begin
    kind_d       = KIND_WRITE;
    address_d    = 32'd0;
    data_d       = 32'd0;
    count_d      = 3'd0;
    plane_d      = 2'd0;
    mask_d       = 8'd0;
    set_d        = 1'b0;
    wsel_d       = 1'b0;
    wpos_d       = 16'd0;
    bank_known_d = bank_known_q;
    cur_bank_d   = cur_bank_q;
    if (planar) begin
      kind_d    = KIND_PLANE;
      address_d = addr_q;
      plane_d   = cmd_i.plane;
      mask_d    = MASK_TOP_BIT >> x_q[2:0];
      set_d     = c_q[cmd_i.plane];
    end else if (need_move) begin
      kind_d       = KIND_MOVE;
      wsel_d       = win_sel_q;
      wpos_d       = wpos_full[15:0];
      bank_known_d = 1'b1;
      cur_bank_d   = bank;
    end else begin
      kind_d    = KIND_WRITE;
      address_d = banked_q ? {16'd0, addr_q[15:0]} : addr_q;
      data_d    = color_masked;
      count_d   = fmt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_known_q <= 1'b0;
      cur_bank_q   <= 16'd0;
    end else if (cmd_i.load_out) begin
      bank_known_q <= bank_known_d;
      cur_bank_q   <= cur_bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q <= pos_x_i;
      y_q <= pos_y_i;
      c_q <= pixel_color_i;
    end
    if (cmd_i.load_line) begin
      line_q <= row_bytes_q * y_q;
      drop_q <= (x_q >= width_q) || (y_q >= height_q) || (fmt_q > FMT_32BPP);
    end
    if (cmd_i.load_addr) begin
      addr_q <= line_q + offset;
    end
    if (cmd_i.load_out) begin
      kind_q    <= kind_d;
      address_q <= address_d;
      data_q    <= data_d;
      count_q   <= count_d;
      plane_q   <= plane_d;
      mask_q    <= mask_d;
      set_q     <= set_d;
      wsel_q    <= wsel_d;
      wpos_q    <= wpos_d;
      last_q    <= res_last;
    end
  end

  assign sts_o.drop = drop_q;
  assign sts_o.last = res_last;

  assign kind_o            = kind_q;
  assign address_o         = address_q;
  assign write_data_o      = data_q;
  assign byte_count_o      = count_q;
  assign plane_o           = plane_q;
  assign bit_mask_o        = mask_q;
  assign set_bit_o         = set_q;
  assign window_select_o   = wsel_q;
  assign window_position_o = wpos_q;
  assign last_o            = last_q;

endmodule

`default_nettype wire

// ----- rtl/framebuffer_pixel_write_unit.sv -----
// Top level: pixel write to framebuffer transaction generator.
// An accepted pixel's first result passes the row multiply, address add and result
//   register in turn; clipped pixels give none.
// Results: 1, 2 or 4 per pixel (0 when clipped), walked by the sequencer one
//   result per cycle, while the output is not held back, through a single output
//   register; the next pixel is accepted once its last result is loaded.
// Reset: rst_ni asynchronous, active low; restores register defaults and forgets the bank.
`timescale 1ns / 1ps
`default_nettype none

module framebuffer_pixel_write_unit import fpwu_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // pixel transactions
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] pos_x_i,
  input  wire logic [15:0] pos_y_i,
  input  wire logic [31:0] pixel_color_i,
  // memory / window transactions
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [31:0]      address_o,
  output logic [31:0]      write_data_o,
  output logic [2:0]       byte_count_o,
  output logic [1:0]       plane_o,
  output logic [7:0]       bit_mask_o,
  output logic             set_bit_o,
  output logic             window_select_o,
  output logic [15:0]      window_position_o,
  output logic             last_o
);

  cmd_t cmd;
  sts_t sts;

  // Controller: steps each pixel through multiply, add and result emission,
  // and owns the output valid flag so the next pixel can enter while the
  // final result of the previous one is still waiting.
  fpwu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: config registers, row_bytes*y, offset add, bank compare and
  // the payload register of the outgoing transaction.
  fpwu_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .pixel_color_i     (pixel_color_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .kind_o            (kind_o),
    .address_o         (address_o),
    .write_data_o      (write_data_o),
    .byte_count_o      (byte_count_o),
    .plane_o           (plane_o),
    .bit_mask_o        (bit_mask_o),
    .set_bit_o         (set_bit_o),
    .window_select_o   (window_select_o),
    .window_position_o (window_position_o),
    .last_o            (last_o)
  );

  // A window move always precedes its write, so it never closes a pixel.
  a_move_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_MOVE) |-> !last_o)
    else $error("window move flagged as last transaction");

  // Planar pixels close on the final plane.
  a_plane_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_PLANE) && last_o |-> (plane_o == LAST_PLANE))
    else $error("planar update closed on wrong plane");

  // One pixel in flight: acceptance drops ready in the next cycle.
  a_one_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second pixel accepted while busy");

endmodule

`default_nettype wire
